[rtl/core/curve_point_and_unit_tangent_assert.svh]
// ----------------------------------------------------------------------------
// curve point and unit tangent assertion macros
// concurrent checks on clk with an active-low asynchronous reset rst_n
// ----------------------------------------------------------------------------
`ifndef CURVE_POINT_AND_UNIT_TANGENT_ASSERT_SVH
`define CURVE_POINT_AND_UNIT_TANGENT_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define CPUT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cput assertion failed");

// antecedent implies consequent in the next cycle
`define CPUT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cput assertion failed");

`else

`define CPUT_ASSERT_IMP(lbl, ante, cons)
`define CPUT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/core/cput_pkg.sv]
// ----------------------------------------------------------------------------
// cput_pkg
// constants, codes and helper functions of the curve point and tangent block
// ----------------------------------------------------------------------------
package cput_pkg;

    typedef enum logic [1:0] {
        CMD_CIRCLE  = 2'd0,
        CMD_ELLIPSE = 2'd1,
        CMD_HELIX   = 2'd2
    } cmd_t;

    // round(2^32 / (2 pi)) and round(2 pi * 2^30)
    localparam logic [29:0] TURN_SCALE = 30'd683565276;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [15:0] TG_ONE     = 16'd16384;

    // horner divisors, lane 0 sine, lane 1 cosine
    localparam logic [5:0] HDIV [2][4] = '{
        '{6'd42, 6'd20, 6'd6,  6'd2},
        '{6'd56, 6'd30, 6'd12, 6'd2}
    };

    localparam logic [31:0] RECIP [2][4] = '{
        '{32'(64'h1_0000_0000 / 64'd42), 32'(64'h1_0000_0000 / 64'd20),
          32'(64'h1_0000_0000 / 64'd6),  32'(64'h1_0000_0000 / 64'd2)},
        '{32'(64'h1_0000_0000 / 64'd56), 32'(64'h1_0000_0000 / 64'd30),
          32'(64'h1_0000_0000 / 64'd12), 32'(64'h1_0000_0000 / 64'd2)}
    };

    // reciprocal estimate is low by at most one, fix it up
    function automatic logic [30:0] fix_quot(input logic [30:0] y,
                                             input logic [62:0] prod,
                                             input logic [5:0]  d);
        logic [30:0] est;
        logic [37:0] rem;
        est = prod[62:32];
        rem = 38'(y) - 38'(est) * 38'(d);
        return (rem >= 38'(d)) ? est + 31'd1 : est;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return 32'(v);
    endfunction

endpackage

[rtl/core/curve_point_and_unit_tangent.sv]
// depth: 70 register stages; the 32-step square root and 16-step divide set the depth
// throughput: one item per cycle while the output register is not stalled
// the whole pipeline stalls only while the output register holds an item not taken
// reset clears every stage valid bit at once; payload registers are not reset
// ----------------------------------------------------------------------------
// curve_point_and_unit_tangent
// point and unit tangent of a circle, ellipse or helix at a given angle
// ----------------------------------------------------------------------------
`include "curve_point_and_unit_tangent_assert.svh"

module curve_point_and_unit_tangent
    import cput_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle, x_radius, y_radius, pitch
    input  logic [119:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x, point_y, point_z, tan_x, tan_y, tan_z
    output logic [143:0] m_tdata,
    // tangent_valid
    output logic [0:0]   m_tuser
);

    localparam int S_PHASE = 1;
    localparam int S_X     = 2;
    localparam int S_X2    = 3;
    localparam int S_FIX0  = 4;
    localparam int S_ROT   = 14;
    localparam int S_PT    = 15;
    localparam int S_LZ    = 16;
    localparam int S_NORM  = 17;
    localparam int S_SQ    = 18;
    localparam int S_SUM   = 19;
    localparam int S_ROOT  = 20;
    localparam int S_DIVI  = 52;
    localparam int S_DIV   = 53;
    localparam int S_OUT   = 69;
    localparam int NS      = 70;

    typedef struct packed {
        logic                    helix;
        logic [30:0]             rx;
        logic [30:0]             ry;
        logic signed [31:0]      pitch;
        logic signed [54:0]      prod;
        logic [1:0]              q;
        logic                    negr;
        logic [62:0]             xm;
        logic signed [62:0]      zp;
        logic [62:0]             m2p;
        logic [29:0]             x;
        logic [59:0]             xx;
        logic [29:0]             x2;
        logic signed [31:0]      pz;
        logic [1:0][30:0]        ha;
        logic [1:0][60:0]        hp;
        logic [1:0][30:0]        hy;
        logic [1:0][62:0]        he;
        logic signed [63:0]      pxp;
        logic signed [63:0]      pyp;
        logic signed [31:0]      px;
        logic signed [31:0]      py;
        logic [2:0][60:0]        m;
        logic [2:0]              neg;
        logic [60:0]             mx;
        logic                    tv;
        logic [5:0]              lz;
        logic [2:0][29:0]        ms;
        logic [2:0][59:0]        sq;
        logic [61:0]             sv;
        logic [62:0]             sr;
        logic [30:0]             lv;
        logic [2:0][46:0]        num;
        logic [2:0][15:0]        quo;
        logic [2:0][15:0]        tg;
    } stage_t;

    stage_t      pipe_reg  [NS];
    stage_t      pipe_next [NS];
    logic [NS-1:0] vld_reg;
    logic        en;

    assign en       = !vld_reg[NS-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        logic [31:0]        phase;
        logic [1:0]         qv;
        logic [31:0]        r;
        logic [29:0]        a;
        logic signed [30:0] turns;
        logic [31:0]        ap;
        logic signed [31:0] ss;
        logic signed [31:0] cc;
        logic signed [31:0] sn;
        logic signed [31:0] cs;
        logic [31:0]        abs_sn;
        logic [31:0]        abs_cs;
        logic [60:0]        mxv;
        logic [5:0]         lzv;
        logic [62:0]        trial;
        logic [46:0]        lsh;
        logic [15:0]        qc;

        phase  = '0;
        qv     = '0;
        r      = '0;
        a      = '0;
        turns  = '0;
        ap     = '0;
        ss     = '0;
        cc     = '0;
        sn     = '0;
        cs     = '0;
        abs_sn = '0;
        abs_cs = '0;
        mxv    = '0;
        lzv    = '0;
        trial  = '0;
        lsh    = '0;
        qc     = '0;

        // input stage
        pipe_next[0]       = pipe_reg[0];
        pipe_next[0].helix = (s_tuser == CMD_HELIX);
        pipe_next[0].rx    = s_tdata[54:24];
        pipe_next[0].ry    = (s_tuser == CMD_ELLIPSE) ? s_tdata[85:55] : s_tdata[54:24];
        pipe_next[0].pitch = signed'(s_tdata[117:86]);
        pipe_next[0].prod  = signed'(s_tdata[23:0]) * signed'({1'b0, TURN_SCALE});

        for (int i = 1; i < NS; i++)
        begin
            pipe_next[i] = pipe_reg[i-1];
        end

        // turn phase, quadrant and reduced angle
        phase = pipe_reg[S_PHASE-1].prod[47:16];
        qv    = 2'((phase + 32'h2000_0000) >> 30);
        r     = phase - {qv, 30'b0};
        a     = r[31] ? 30'(-r) : 30'(r);
        turns = 31'((pipe_reg[S_PHASE-1].prod + 55'sd8388608) >>> 24);
        ap    = pipe_reg[S_PHASE-1].pitch[31] ? 32'(-pipe_reg[S_PHASE-1].pitch)
                                              : 32'(pipe_reg[S_PHASE-1].pitch);
        pipe_next[S_PHASE].q    = qv;
        pipe_next[S_PHASE].negr = r[31];
        pipe_next[S_PHASE].xm   = 63'(a) * 63'(TWO_PI_Q30);
        pipe_next[S_PHASE].zp   = pipe_reg[S_PHASE-1].pitch * turns;
        pipe_next[S_PHASE].m2p  = 63'(ap) * 63'(TURN_SCALE);

        // radians, z and the helix slope
        pipe_next[S_X].x  = pipe_reg[S_X-1].xm[61:32];
        pipe_next[S_X].xx = 60'(pipe_reg[S_X-1].xm[61:32]) * 60'(pipe_reg[S_X-1].xm[61:32]);
        pipe_next[S_X].pz = pipe_reg[S_X-1].helix
                          ? sat32(64'((pipe_reg[S_X-1].zp + 63'sd8388608) >>> 24)) : '0;
        pipe_next[S_X].m[2] = pipe_reg[S_X-1].helix
                            ? 61'((pipe_reg[S_X-1].m2p + 63'd2) >> 2) : '0;

        // first horner term
        pipe_next[S_X2].x2 = pipe_reg[S_X2-1].xx[59:30];
        for (int l = 0; l < 2; l++)
        begin
            pipe_next[S_X2].hy[l] = 31'(pipe_reg[S_X2-1].xx[59:30]);
            pipe_next[S_X2].he[l] = 63'(pipe_reg[S_X2-1].xx[59:30]) * 63'(RECIP[l][0]);
            pipe_next[S_FIX0].ha[l] = ONE_Q30 - fix_quot(pipe_reg[S_FIX0-1].hy[l],
                                                         pipe_reg[S_FIX0-1].he[l], HDIV[l][0]);
        end

        // remaining horner steps, three stages each; sine ends with x * a
        for (int k = 1; k < 4; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (l == 0 && k == 3)
                    pipe_next[2+3*k].hp[l] = 61'(pipe_reg[1+3*k].x) * 61'(pipe_reg[1+3*k].ha[l]);
                else
                    pipe_next[2+3*k].hp[l] = 61'(pipe_reg[1+3*k].x2) * 61'(pipe_reg[1+3*k].ha[l]);
                pipe_next[3+3*k].hy[l] = pipe_reg[2+3*k].hp[l][60:30];
                pipe_next[3+3*k].he[l] = 63'(pipe_reg[2+3*k].hp[l][60:30]) * 63'(RECIP[l][k]);
                if (!(l == 0 && k == 3))
                    pipe_next[4+3*k].ha[l] = ONE_Q30 - fix_quot(pipe_reg[3+3*k].hy[l],
                                                               pipe_reg[3+3*k].he[l], HDIV[l][k]);
            end
        end

        // quadrant rotation and radius products
        ss = pipe_reg[S_ROT-1].negr ? -signed'({1'b0, pipe_reg[S_ROT-1].hy[0]})
                                    :  signed'({1'b0, pipe_reg[S_ROT-1].hy[0]});
        cc = signed'({1'b0, pipe_reg[S_ROT-1].ha[1]});
        unique case (pipe_reg[S_ROT-1].q)
            2'd0:
            begin
                sn = ss;
                cs = cc;
            end
            2'd1:
            begin
                sn = cc;
                cs = -ss;
            end
            2'd2:
            begin
                sn = -ss;
                cs = -cc;
            end
            default:
            begin
                sn = -cc;
                cs = ss;
            end
        endcase
        abs_sn = sn[31] ? 32'(-sn) : 32'(sn);
        abs_cs = cs[31] ? 32'(-cs) : 32'(cs);
        pipe_next[S_ROT].pxp    = signed'({1'b0, pipe_reg[S_ROT-1].rx}) * cs;
        pipe_next[S_ROT].pyp    = signed'({1'b0, pipe_reg[S_ROT-1].ry}) * sn;
        pipe_next[S_ROT].m[0]   = 61'(pipe_reg[S_ROT-1].rx) * 61'(abs_sn);
        pipe_next[S_ROT].m[1]   = 61'(pipe_reg[S_ROT-1].ry) * 61'(abs_cs);
        pipe_next[S_ROT].neg[0] = (sn > 32'sd0);
        pipe_next[S_ROT].neg[1] = cs[31];
        pipe_next[S_ROT].neg[2] = pipe_reg[S_ROT-1].helix & pipe_reg[S_ROT-1].pitch[31];

        // rounded points and the largest tangent magnitude
        pipe_next[S_PT].px = sat32((pipe_reg[S_PT-1].pxp + 64'sd536870912) >>> 30);
        pipe_next[S_PT].py = sat32((pipe_reg[S_PT-1].pyp + 64'sd536870912) >>> 30);
        mxv = pipe_reg[S_PT-1].m[0];
        if (pipe_reg[S_PT-1].m[1] > mxv)
            mxv = pipe_reg[S_PT-1].m[1];
        if (pipe_reg[S_PT-1].m[2] > mxv)
            mxv = pipe_reg[S_PT-1].m[2];
        pipe_next[S_PT].mx = mxv;
        pipe_next[S_PT].tv = (mxv != '0);

        // leading one of the largest magnitude
        for (int b = 0; b < 61; b++)
        begin
            if (pipe_reg[S_LZ-1].mx[b])
                lzv = 6'(b);
        end
        pipe_next[S_LZ].lz = lzv;

        // align the top bit to bit 29, then square and sum
        for (int l = 0; l < 3; l++)
        begin
            if (pipe_reg[S_NORM-1].lz >= 6'd29)
                pipe_next[S_NORM].ms[l] = 30'(pipe_reg[S_NORM-1].m[l]
                                              >> (pipe_reg[S_NORM-1].lz - 6'd29));
            else
                pipe_next[S_NORM].ms[l] = 30'(pipe_reg[S_NORM-1].m[l][29:0]
                                              << (6'd29 - pipe_reg[S_NORM-1].lz));
            pipe_next[S_SQ].sq[l] = 60'(pipe_reg[S_SQ-1].ms[l]) * 60'(pipe_reg[S_SQ-1].ms[l]);
        end
        pipe_next[S_SUM].sv = 62'(pipe_reg[S_SUM-1].sq[0]) + 62'(pipe_reg[S_SUM-1].sq[1])
                            + 62'(pipe_reg[S_SUM-1].sq[2]);
        pipe_next[S_SUM].sr = '0;

        // square root, one result bit a stage
        for (int j = 0; j < 32; j++)
        begin
            trial = pipe_reg[S_ROOT+j-1].sr + (63'd1 << (62 - 2*j));
            if (63'(pipe_reg[S_ROOT+j-1].sv) >= trial)
            begin
                pipe_next[S_ROOT+j].sv = 62'(63'(pipe_reg[S_ROOT+j-1].sv) - trial);
                pipe_next[S_ROOT+j].sr = (pipe_reg[S_ROOT+j-1].sr >> 1) + (63'd1 << (62 - 2*j));
            end
            else
            begin
                pipe_next[S_ROOT+j].sr = pipe_reg[S_ROOT+j-1].sr >> 1;
            end
        end

        // rounded quotient m * 16384 / len
        pipe_next[S_DIVI].lv = pipe_reg[S_DIVI-1].sr[30:0];
        for (int l = 0; l < 3; l++)
        begin
            pipe_next[S_DIVI].num[l] = 47'({pipe_reg[S_DIVI-1].ms[l], 14'b0})
                                     + 47'(pipe_reg[S_DIVI-1].sr[30:1]);
            pipe_next[S_DIVI].quo[l] = '0;
        end
        for (int j = 0; j < 16; j++)
        begin
            lsh = 47'(pipe_reg[S_DIV+j-1].lv) << (15 - j);
            for (int l = 0; l < 3; l++)
            begin
                if (pipe_reg[S_DIV+j-1].num[l] >= lsh)
                begin
                    pipe_next[S_DIV+j].num[l]        = pipe_reg[S_DIV+j-1].num[l] - lsh;
                    pipe_next[S_DIV+j].quo[l][15-j]  = 1'b1;
                end
            end
        end

        // clamp, sign and blank
        for (int l = 0; l < 3; l++)
        begin
            qc = (pipe_reg[S_OUT-1].quo[l] > TG_ONE) ? TG_ONE : pipe_reg[S_OUT-1].quo[l];
            if (!pipe_reg[S_OUT-1].tv)
                pipe_next[S_OUT].tg[l] = '0;
            else if (pipe_reg[S_OUT-1].neg[l])
                pipe_next[S_OUT].tg[l] = 16'(-qc);
            else
                pipe_next[S_OUT].tg[l] = qc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NS; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {pipe_reg[NS-1].tg[2], pipe_reg[NS-1].tg[1], pipe_reg[NS-1].tg[0],
                       pipe_reg[NS-1].pz, pipe_reg[NS-1].py, pipe_reg[NS-1].px};
    assign m_tuser  = pipe_reg[NS-1].tv;

    `CPUT_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready)
    `CPUT_ASSERT_NXT(a_item_enters, s_tvalid && s_tready, vld_reg[0])
    `CPUT_ASSERT_IMP(a_root_floor, vld_reg[S_DIVI-1] && pipe_reg[S_DIVI-1].tv,
                     pipe_reg[S_DIVI-1].sr >= 63'h2000_0000)
    `CPUT_ASSERT_IMP(a_quot_bound, vld_reg[S_OUT-1] && pipe_reg[S_OUT-1].tv,
                     pipe_reg[S_OUT-1].quo[0] <= TG_ONE && pipe_reg[S_OUT-1].quo[1] <= TG_ONE
                     && pipe_reg[S_OUT-1].quo[2] <= TG_ONE)

endmodule
